// File: sv/fpfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpfm_pkg;

   localparam int unsigned QuoWidth     = 45;
   localparam int unsigned BitsPerStage = 3;
   localparam int unsigned DivStages    = QuoWidth / BitsPerStage;
   localparam int unsigned NumAxes      = 3;
   localparam int unsigned DiagShift    = 13;

   localparam logic [31:0] WOne      = 32'h0000_1000;
   localparam logic [63:0] RoundBias = 64'h0000_0000_8000_0000;
   localparam logic [63:0] TruncBias = 64'd4095;

   typedef struct packed {
      logic [31:0]          dvs;
      logic [31:0]          rem;
      logic [QuoWidth-1:0]  quo;
      logic [31:0]          sf;
      logic                 neg;
      logic                 zero;
   } div_type;

   typedef struct packed {
      logic [63:0] q;
      logic [31:0] sf;
      logic        zero;
   } axis_type;

   typedef struct packed {
      logic [63:0] m0;
      logic [31:0] m1;
      logic [31:0] m2;
   } prod_type;

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [32:0] div_step(input logic [31:0] dvs,
                                            input logic [31:0] rem,
                                            input logic        bit_in);
      logic [32:0] trial;
      logic [32:0] diff;
      trial = {rem, bit_in};
      diff  = trial - {1'b0, dvs};
      if (trial >= {1'b0, dvs}) begin
         return {1'b1, diff[31:0]};
      end
      return {1'b0, trial[31:0]};
   endfunction

endpackage
`default_nettype wire

// File: sv/fixed_point_frustum_matrix_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Perspective frustum matrix in 20.12 fixed point. One request may enter every
// cycle while no result is held at the output. The reciprocal divider resolves
// 45 quotient bits at three bits per stage over 15 stages, followed by five
// stages of sign fixup, w scaling multiply, truncation, rounding multiply and
// output. All stages hold together while a result waits on rsp_ready. w_scale
// resets to 4096 (one) and is written through the csr port, which is always
// ready.
module fixed_point_frustum_matrix_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic signed [31:0] req_bound_top,
   input  wire logic signed [31:0] req_bound_bottom,
   input  wire logic signed [31:0] req_bound_left,
   input  wire logic signed [31:0] req_bound_right,
   input  wire logic signed [31:0] req_bound_near,
   input  wire logic signed [31:0] req_bound_far,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_x_scale,
   output logic signed [31:0] rsp_y_scale,
   output logic signed [31:0] rsp_z_scale,
   output logic signed [31:0] rsp_x_skew,
   output logic signed [31:0] rsp_y_skew,
   output logic signed [31:0] rsp_z_skew,
   output logic signed [31:0] rsp_w_term,
   output logic             rsp_zero_divisor,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic signed [31:0] csr_w_scale
);
   import fpfm_pkg::*;

   logic advance;
   logic [31:0] w_scale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_scale_ff <= WOne;
      end else if (csr_valid && csr_ready) begin
         w_scale_ff <= csr_w_scale;
      end
   end

   // ---------------- stage 0: differences ----------------
   logic [31:0] top_u, bot_u, left_u, right_u, near_u, far_u;
   logic [NumAxes-1:0][31:0] diff_w, sf_w;
   div_type [NumAxes-1:0] div0_in;

   div_type [NumAxes-1:0] div_ff [0:DivStages];
   logic                  div_vld_ff [0:DivStages];
   logic [31:0]           div_ws_ff [0:DivStages];

   assign top_u   = req_bound_top;
   assign bot_u   = req_bound_bottom;
   assign left_u  = req_bound_left;
   assign right_u = req_bound_right;
   assign near_u  = req_bound_near;
   assign far_u   = req_bound_far;

   always_comb begin
      diff_w[0] = right_u - left_u;
      diff_w[1] = top_u - bot_u;
      diff_w[2] = near_u - far_u;
      sf_w[0]   = 32'd0 - (right_u + left_u);
      sf_w[1]   = 32'd0 - (top_u + bot_u);
      sf_w[2]   = far_u + near_u;
      for (int a = 0; a < NumAxes; a++) begin
         div0_in[a].dvs  = diff_w[a][31] ? (32'd0 - diff_w[a]) : diff_w[a];
         div0_in[a].rem  = '0;
         div0_in[a].quo  = '0;
         div0_in[a].sf   = sf_w[a];
         div0_in[a].neg  = diff_w[a][31];
         div0_in[a].zero = (diff_w[a] == 32'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff[0] <= 1'b0;
      end else if (advance) begin
         div_vld_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff[0]    <= div0_in;
         div_ws_ff[0] <= w_scale_ff;
      end
   end

   // ---------------- divider stages ----------------
   for (genvar s = 1; s <= DivStages; s++) begin : g_div
      div_type [NumAxes-1:0] stage_in;

      always_comb begin
         logic [32:0] step;
         step = '0;
         for (int a = 0; a < NumAxes; a++) begin
            stage_in[a] = div_ff[s-1][a];
            for (int j = 0; j < BitsPerStage; j++) begin
               step = div_step(stage_in[a].dvs, stage_in[a].rem,
                               (((s - 1) * BitsPerStage + j) == 0));
               stage_in[a].rem = step[31:0];
               stage_in[a].quo = {stage_in[a].quo[QuoWidth-2:0], step[32]};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[s] <= 1'b0;
         end else if (advance) begin
            div_vld_ff[s] <= div_vld_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[s]    <= stage_in;
            div_ws_ff[s] <= div_ws_ff[s-1];
         end
      end
   end

   // ---------------- sign fixup ----------------
   axis_type [NumAxes-1:0] sg_ff, sg_in;
   logic                   sg_vld_ff;
   logic [31:0]            sg_ws_ff;

   always_comb begin
      for (int a = 0; a < NumAxes; a++) begin
         sg_in[a].q    = div_ff[DivStages][a].neg ?
                         (64'd0 - 64'(div_ff[DivStages][a].quo)) :
                         64'(div_ff[DivStages][a].quo);
         sg_in[a].sf   = div_ff[DivStages][a].sf;
         sg_in[a].zero = div_ff[DivStages][a].zero;
      end
   end

   // ---------------- w scale products ----------------
   axis_type [NumAxes-1:0] sc_ff;
   prod_type [NumAxes-1:0] sc_prod_ff, sc_prod_in;
   logic                   sc_vld_ff;
   logic [31:0]            sc_ws_ff;
   logic [31:0]            ws_hi;

   assign ws_hi = {32{sg_ws_ff[31]}};

   always_comb begin
      for (int a = 0; a < NumAxes; a++) begin
         sc_prod_in[a].m0 = {32'd0, sg_ff[a].q[31:0]} * {32'd0, sg_ws_ff};
         sc_prod_in[a].m1 = sg_ff[a].q[31:0] * ws_hi;
         sc_prod_in[a].m2 = sg_ff[a].q[63:32] * sg_ws_ff;
      end
   end

   // ---------------- truncate by 4096 ----------------
   axis_type [NumAxes-1:0] tr_ff, tr_in;
   logic                   tr_vld_ff;
   logic [31:0]            tr_ws_ff;

   always_comb begin
      logic [63:0] prod;
      logic [63:0] adj;
      prod = '0;
      adj  = '0;
      for (int a = 0; a < NumAxes; a++) begin
         prod = sc_prod_ff[a].m0 +
                {sc_prod_ff[a].m1 + sc_prod_ff[a].m2, 32'd0};
         adj  = prod + (prod[63] ? TruncBias : 64'd0);
         tr_in[a].q    = (sc_ws_ff == WOne) ? sc_ff[a].q : {{12{adj[63]}}, adj[63:12]};
         tr_in[a].sf   = sc_ff[a].sf;
         tr_in[a].zero = sc_ff[a].zero;
      end
   end

   // ---------------- diagonal and skew products ----------------
   logic [NumAxes-1:0][31:0] dg_ff, dg_in;
   prod_type [NumAxes-1:0]   sk_prod_ff, sk_prod_in;
   logic [NumAxes-1:0]       dg_zero_ff;
   logic                     dg_vld_ff;
   logic [31:0]              dg_ws_ff;

   always_comb begin
      logic [63:0] dsum;
      dsum = '0;
      for (int a = 0; a < NumAxes; a++) begin
         dsum = {tr_ff[a].q[63-DiagShift:0], {DiagShift{1'b0}}} + RoundBias;
         dg_in[a] = dsum[63:32];
         sk_prod_in[a].m0 = {32'd0, tr_ff[a].q[31:0]} * {32'd0, tr_ff[a].sf};
         sk_prod_in[a].m1 = tr_ff[a].q[31:0] * {32{tr_ff[a].sf[31]}};
         sk_prod_in[a].m2 = tr_ff[a].q[63:32] * tr_ff[a].sf;
      end
   end

   // ---------------- output ----------------
   logic [NumAxes-1:0][31:0] sk_in;
   logic [NumAxes-1:0][31:0] out_scale_ff, out_skew_ff;
   logic [31:0]              out_ws_ff;
   logic                     out_zero_ff;
   logic                     out_vld_ff;

   always_comb begin
      logic [63:0] ssum;
      ssum = '0;
      for (int a = 0; a < NumAxes; a++) begin
         ssum = sk_prod_ff[a].m0 + {sk_prod_ff[a].m1 + sk_prod_ff[a].m2, 32'd0} +
                RoundBias;
         sk_in[a] = ssum[63:32];
      end
   end

   assign advance = !out_vld_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         sg_vld_ff  <= 1'b0;
         sc_vld_ff  <= 1'b0;
         tr_vld_ff  <= 1'b0;
         dg_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         sg_vld_ff  <= div_vld_ff[DivStages];
         sc_vld_ff  <= sg_vld_ff;
         tr_vld_ff  <= sc_vld_ff;
         dg_vld_ff  <= tr_vld_ff;
         out_vld_ff <= dg_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sg_ff      <= sg_in;
         sg_ws_ff   <= div_ws_ff[DivStages];
         sc_ff      <= sg_ff;
         sc_prod_ff <= sc_prod_in;
         sc_ws_ff   <= sg_ws_ff;
         tr_ff      <= tr_in;
         tr_ws_ff   <= sc_ws_ff;
         dg_ff      <= dg_in;
         sk_prod_ff <= sk_prod_in;
         dg_ws_ff   <= tr_ws_ff;
         for (int a = 0; a < NumAxes; a++) begin
            dg_zero_ff[a]   <= tr_ff[a].zero;
            out_scale_ff[a] <= dg_zero_ff[a] ? 32'd0 : dg_ff[a];
            out_skew_ff[a]  <= dg_zero_ff[a] ? 32'd0 : sk_in[a];
         end
         out_ws_ff   <= dg_ws_ff;
         out_zero_ff <= |dg_zero_ff;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_x_scale      = out_scale_ff[0];
   assign rsp_y_scale      = out_scale_ff[1];
   assign rsp_z_scale      = out_scale_ff[2];
   assign rsp_x_skew       = out_skew_ff[0];
   assign rsp_y_skew       = out_skew_ff[1];
   assign rsp_z_skew       = out_skew_ff[2];
   assign rsp_w_term       = out_ws_ff;
   assign rsp_zero_divisor = out_zero_ff;

   a_stall_holds_div : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(div_vld_ff[DivStages]))
      else $error("divider valid moved during stall");

   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

   a_div_to_sign : assert property (@(posedge clock) disable iff (reset)
      advance && div_vld_ff[DivStages] |=> sg_vld_ff)
      else $error("request lost after divider");

   a_csr_write : assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> w_scale_ff == $past(csr_w_scale))
      else $error("w scale write not captured");

endmodule
`default_nettype wire

// File: dv/fixed_point_frustum_matrix_unit_tb.sv
`timescale 1ns / 1ps
module fixed_point_frustum_matrix_unit_tb;
   import fpfm_pkg::*;

   typedef struct packed {
      logic [31:0] top, bottom, left, right, near_b, far_b;
   } frustum_type;

   typedef struct packed {
      logic [31:0] x_scale, y_scale, z_scale, x_skew, y_skew, z_skew, w_term;
      logic        zero_divisor;
   } matrix_type;

   typedef struct packed {
      frustum_type bounds;
      logic        known;
      matrix_type  matrix;
   } stim_row_type;

   localparam int WatchLimit = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_bound_top = '0, req_bound_bottom = '0, req_bound_left = '0;
   logic signed [31:0] req_bound_right = '0, req_bound_near = '0, req_bound_far = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_x_scale, rsp_y_scale, rsp_z_scale;
   logic signed [31:0] rsp_x_skew, rsp_y_skew, rsp_z_skew, rsp_w_term;
   logic rsp_zero_divisor;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic signed [31:0] csr_w_scale = '0;

   logic [31:0] w_scale_now = WOne;
   matrix_type  matrix_q[$];
   matrix_type  typed_q[$];
   logic        typed_flag_q[$];
   int          err_count = 0;
   int          idle_cycles = 0;
   bit          calm = 1'b0;
   bit          hold_long = 1'b0;

   fixed_point_frustum_matrix_unit dut (.*);

   always #5 clock = ~clock;

   function automatic void axis_terms(input logic [31:0] diff, input logic [31:0] sf,
                                      input logic [31:0] ws, output logic [31:0] diag,
                                      output logic [31:0] skew, output logic zero);
      longint d, r, w, s;
      logic [63:0] t;
      d = $signed(diff);
      w = $signed(ws);
      s = $signed(sf);
      diag = '0;
      skew = '0;
      zero = (d == 0);
      if (!zero) begin
         r = (longint'(1) << 44) / d;
         if (w != 4096) r = (r * w) / 4096;
         t = (r << DiagShift) + longint'(RoundBias);
         diag = t[63:32];
         t = (r * s) + longint'(RoundBias);
         skew = t[63:32];
      end
   endfunction

   function automatic matrix_type frustum_matrix(input frustum_type b, input logic [31:0] ws);
      matrix_type m;
      logic zx, zy, zz;
      axis_terms(b.right - b.left, 32'd0 - (b.right + b.left), ws, m.x_scale, m.x_skew, zx);
      axis_terms(b.top - b.bottom, 32'd0 - (b.top + b.bottom), ws, m.y_scale, m.y_skew, zy);
      axis_terms(b.near_b - b.far_b, b.far_b + b.near_b, ws, m.z_scale, m.z_skew, zz);
      m.w_term = ws;
      m.zero_divisor = zx | zy | zz;
      return m;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         err_count++;
      end
   endtask

   task automatic send_request(input frustum_type b, input logic known,
                               input matrix_type typed);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_bound_top, req_bound_bottom, req_bound_left} <= {b.top, b.bottom, b.left};
      {req_bound_right, req_bound_near, req_bound_far} <= {b.right, b.near_b, b.far_b};
      do @(posedge clock); while (!req_ready);
      matrix_q.push_back(frustum_matrix(b, w_scale_now));
      typed_q.push_back(typed);
      typed_flag_q.push_back(known);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (matrix_q.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_w_scale(input logic [31:0] v);
      csr_valid <= 1'b1;
      csr_w_scale <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      w_scale_now = v;
   endtask

   function automatic logic [31:0] rand_bound();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 65535) - 32768;
         1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)};
         2: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic frustum_type rand_frustum();
      frustum_type b;
      b = {rand_bound(), rand_bound(), rand_bound(), rand_bound(), rand_bound(), rand_bound()};
      if ($urandom_range(0, 9) == 0) b.right = b.left;
      if ($urandom_range(0, 9) == 0) b.top = b.bottom;
      if ($urandom_range(0, 9) == 0) b.near_b = b.far_b;
      if ($urandom_range(0, 7) == 0) b.right = b.left + $urandom_range(0, 2) - 1;
      return b;
   endfunction

   // receiver side
   initial begin
      int n;
      forever begin
         n = calm ? 0 : $urandom_range(0, 19);
         if (hold_long) begin
            n = 400;
            hold_long = 1'b0;
         end
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (matrix_q.size() == 0) begin
            $error("result with no request pending");
            err_count++;
         end else begin
            matrix_type e;
            e = typed_flag_q[0] ? typed_q[0] : matrix_q[0];
            check_field("x_scale", e.x_scale, rsp_x_scale);
            check_field("y_scale", e.y_scale, rsp_y_scale);
            check_field("z_scale", e.z_scale, rsp_z_scale);
            check_field("x_skew", e.x_skew, rsp_x_skew);
            check_field("y_skew", e.y_skew, rsp_y_skew);
            check_field("z_skew", e.z_skew, rsp_z_skew);
            check_field("w_term", e.w_term, rsp_w_term);
            check_field("zero_divisor", 32'(e.zero_divisor), 32'(rsp_zero_divisor));
            void'(matrix_q.pop_front());
            void'(typed_q.pop_front());
            void'(typed_flag_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("fixed_point_frustum_matrix_unit: mismatch");
         $finish;
      end
   end

   initial begin
      stim_row_type stim_tab[14];
      matrix_type   zero_m;
      logic [31:0]  w_list[10];
      zero_m = '{default: '0, zero_divisor: 1'b1, w_term: WOne};
      stim_tab[0]  = '{bounds: '0, known: 1'b1, matrix: zero_m};
      stim_tab[1]  = '{bounds: {6{32'h7fff_ffff}}, known: 1'b1, matrix: zero_m};
      stim_tab[2]  = '{bounds: {6{32'h8000_0000}}, known: 1'b1, matrix: zero_m};
      stim_tab[3]  = '{bounds: {32'h1000, -32'sh1000, -32'sh1000, 32'h1000, 32'h1000,
                                32'h64000}, known: 1'b0, matrix: '0};
      stim_tab[4]  = '{bounds: {32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                32'h7fff_ffff, 32'h8000_0000}, known: 1'b0, matrix: '0};
      stim_tab[5]  = '{bounds: {32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                                32'h8000_0000, 32'h7fff_ffff}, known: 1'b0, matrix: '0};
      stim_tab[6]  = '{bounds: {32'd1, 32'd0, 32'd0, 32'd1, 32'd1, 32'd0}, known: 1'b0,
                       matrix: '0};
      stim_tab[7]  = '{bounds: {32'd0, 32'd1, 32'd1, 32'd0, 32'd0, 32'd1}, known: 1'b0,
                       matrix: '0};
      stim_tab[8]  = '{bounds: {32'h2000, 32'h2000, -32'sh800, 32'h800, 32'h100, 32'h900},
                       known: 1'b0, matrix: '0};
      stim_tab[9]  = '{bounds: {32'h3000, 32'h1000, 32'h500, 32'h500, 32'h100, 32'h900},
                       known: 1'b0, matrix: '0};
      stim_tab[10] = '{bounds: {32'h3000, 32'h1000, 32'h0, 32'h500, 32'h900, 32'h900},
                       known: 1'b0, matrix: '0};
      stim_tab[11] = '{bounds: {32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff, 32'h0,
                                32'hffff_ffff}, known: 1'b0, matrix: '0};
      stim_tab[12] = '{bounds: {32'h5555_5555, 32'haaaa_aaaa, 32'h3333_3333, 32'hcccc_cccc,
                                32'h0f0f_0f0f, 32'hf0f0_f0f0}, known: 1'b0, matrix: '0};
      stim_tab[13] = '{bounds: {32'h7fff_0000, 32'h0000_0001, 32'h0000_ffff, 32'h8000_0001,
                                32'h0000_1000, 32'h0000_1001}, known: 1'b0, matrix: '0};
      w_list = '{32'h0000_1000, 32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                 32'h0000_2000, 32'h0000_0800, 32'hffff_f000, $urandom, 32'h0000_1000};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_tab[i]) send_request(stim_tab[i].bounds, stim_tab[i].known,
                                         stim_tab[i].matrix);
      drain();

      foreach (w_list[p]) begin
         write_w_scale(w_list[p]);
         if (p == 2) hold_long = 1'b1;
         for (int i = 0; i < 120; i++) begin
            calm = (i % 60) < 12;
            send_request(rand_frustum(), 1'b0, '0);
         end
         calm = 1'b0;
         drain();
      end

      if (err_count == 0)
         $display("fixed_point_frustum_matrix_unit: match");
      else
         $display("fixed_point_frustum_matrix_unit: mismatch");
      $finish;
   end
endmodule
